// File: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the stable priority queue
// Field widths, status codes and the control word broadcast to every cell.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int PRIO_W = 8;
	localparam int TAG_W  = 32;
	localparam int OCC_W  = 5;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_REMOVED  = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_REMOVE = 1'b1
	} mode_t;

	// broadcast to the whole chain each cycle
	typedef struct packed {
		logic              ins;
		logic              rem;
		logic [PRIO_W-1:0] prio;
	} cell_ctrl_t;

endpackage

// File: design/stable_priority_queue_core.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_core: bounded stable priority queue
// Sorted shift chain of CAPACITY cells with a registered result word.
// ----------------------------------------------------------------------------
// Each input word is an insert (mode 0) or a remove of the highest priority
// entry (mode 1) and yields exactly one result word. The queue is a chain of
// CAPACITY cells kept sorted by priority, front at cell 0; an insert lands
// behind all entries of greater or equal priority, so equal priorities leave
// in arrival order. Every cell compares and shifts in the same cycle, so one
// word is taken per clock; its result is loaded into the output register at
// the same edge that takes the word and is offered from the following cycle.
// The only wait is a stalled output register. Inserts into a
// full queue and removes from an empty one leave the state untouched and
// report status FULL or EMPTY. Payloads are stored at PAYLOAD_BITS bits;
// occupancy reports the entry count modulo 32.
module stable_priority_queue_core import spq_pkg::*; #(
	parameter int CAPACITY     = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              mode,
	input  logic [PRIO_W-1:0] priority_req,
	input  logic [TAG_W-1:0]  payload,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [PRIO_W-1:0] out_priority,
	output logic [TAG_W-1:0]  out_payload,
	output logic [OCC_W-1:0]  occupancy
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]        count_q, count_nxt;
	logic                    out_valid_q;
	status_t                 status_q;
	logic [PRIO_W-1:0]       out_prio_q;
	logic [TAG_W-1:0]        out_tag_q;
	logic [OCC_W-1:0]        occ_q;

	logic                    fire, full, empty;
	cell_ctrl_t              ctrl;
	logic [PAYLOAD_BITS-1:0] new_tag;
	status_t                 status_nxt;

	logic [CAPACITY-1:0]     ge;
	logic [PRIO_W-1:0]       c_prio [CAPACITY];
	logic [PAYLOAD_BITS-1:0] c_tag  [CAPACITY];

	assign in_ready = !out_valid_q || out_ready;
	assign fire     = in_valid && in_ready;
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);
	assign new_tag  = PAYLOAD_BITS'(payload);

	always_comb begin
		ctrl.prio  = priority_req;
		ctrl.ins   = fire && (mode == MODE_INSERT) && !full;
		ctrl.rem   = fire && (mode == MODE_REMOVE) && !empty;
		count_nxt  = count_q;
		status_nxt = ST_INSERTED;
		if (mode == MODE_INSERT) begin
			if (full) begin
				status_nxt = ST_FULL;
			end else begin
				status_nxt = ST_INSERTED;
				count_nxt  = count_q + CNT_W'(1);
			end
		end else begin
			if (empty) begin
				status_nxt = ST_EMPTY;
			end else begin
				status_nxt = ST_REMOVED;
				count_nxt  = count_q - CNT_W'(1);
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                    occ_i, prev_ge_i;
		logic [PRIO_W-1:0]       prev_prio_i, next_prio_i;
		logic [PAYLOAD_BITS-1:0] prev_tag_i, next_tag_i;

		assign occ_i = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_front
			assign prev_ge_i   = 1'b1;
			assign prev_prio_i = '0;
			assign prev_tag_i  = '0;
		end else begin : g_mid
			assign prev_ge_i   = ge[i-1];
			assign prev_prio_i = c_prio[i-1];
			assign prev_tag_i  = c_tag[i-1];
		end

		if (i == CAPACITY - 1) begin : g_back
			assign next_prio_i = '0;
			assign next_tag_i  = '0;
		end else begin : g_inner
			assign next_prio_i = c_prio[i+1];
			assign next_tag_i  = c_tag[i+1];
		end

		spq_cell #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.new_tag   (new_tag),
			.occ       (occ_i),
			.prev_ge   (prev_ge_i),
			.prev_prio (prev_prio_i),
			.prev_tag  (prev_tag_i),
			.next_prio (next_prio_i),
			.next_tag  (next_tag_i),
			.ge        (ge[i]),
			.prio      (c_prio[i]),
			.tag       (c_tag[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word; front cell is read before the shift
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= status_nxt;
			occ_q    <= OCC_W'(count_nxt);
			if (status_nxt == ST_REMOVED) begin
				out_prio_q <= c_prio[0];
				out_tag_q  <= TAG_W'(c_tag[0]);
			end else begin
				out_prio_q <= '0;
				out_tag_q  <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_priority = out_prio_q;
	assign out_payload  = out_tag_q;
	assign occupancy    = occ_q;

endmodule

// File: design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted shift chain
// Holds one entry; on insert it keeps, loads the new word or takes its
// front neighbor; on remove it takes its back neighbor.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; #(
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                    clk,
	input  cell_ctrl_t              ctrl,
	input  logic [PAYLOAD_BITS-1:0] new_tag,
	input  logic                    occ,
	input  logic                    prev_ge,
	input  logic [PRIO_W-1:0]       prev_prio,
	input  logic [PAYLOAD_BITS-1:0] prev_tag,
	input  logic [PRIO_W-1:0]       next_prio,
	input  logic [PAYLOAD_BITS-1:0] next_tag,
	output logic                    ge,
	output logic [PRIO_W-1:0]       prio,
	output logic [PAYLOAD_BITS-1:0] tag
);

	logic [PRIO_W-1:0]       prio_q;
	logic [PAYLOAD_BITS-1:0] tag_q;

	// entries at or above the new priority stay put, so ties keep arrival order
	assign ge   = occ && (prio_q >= ctrl.prio);
	assign prio = prio_q;
	assign tag  = tag_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins && !ge) begin
			if (prev_ge) begin
				prio_q <= ctrl.prio;
				tag_q  <= new_tag;
			end else begin
				prio_q <= prev_prio;
				tag_q  <= prev_tag;
			end
		end else if (ctrl.rem) begin
			prio_q <= next_prio;
			tag_q  <= next_tag;
		end
	end

endmodule

// File: design/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker: port-level checks for the stable priority queue
// Watches the result channel and bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker import spq_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [1:0]        status,
	input logic [PRIO_W-1:0] out_priority,
	input logic [TAG_W-1:0]  out_payload,
	input logic [OCC_W-1:0]  occupancy
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(occupancy))
		else $error("result word dropped or changed while stalled");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EMPTY) |-> occupancy == '0)
		else $error("empty report with nonzero occupancy");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL) |-> occupancy == OCC_W'(CAPACITY))
		else $error("full report with wrong occupancy");

	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_REMOVED) |-> out_priority == '0 && out_payload == '0)
		else $error("data present on a non-remove result");

endmodule

bind stable_priority_queue_core spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);
